// ===== hw/rtl/middle_insert_deque_assert.svh =====
// Assertion macros shared by the deque modules.
// Each macro expects clk and rst_n in scope.
`ifndef MIDDLE_INSERT_DEQUE_ASSERT_SVH
`define MIDDLE_INSERT_DEQUE_ASSERT_SVH

// cond holds on every clock edge out of reset
`define MID_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante in one cycle implies cons in the next
`define MID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mideq_pkg.sv =====
package mideq_pkg;

  // Entries per half; must be a power of two (ring pointers wrap naturally).
  localparam int HALF_DEPTH = 512;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(HALF_DEPTH);  // ring pointer
  localparam int CW         = AW + 1;              // per-half count, 0..HALF_DEPTH
  localparam int TW         = 11;                  // total_count field
  localparam int IDX_W      = 10;                  // read_index field
  localparam int REQ_W      = 2;
  localparam int STS_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK   = 2'd0,
    REQ_PUSH_FRONT  = 2'd1,
    REQ_PUSH_MIDDLE = 2'd2,
    REQ_READ        = 2'd3
  } mideq_req_t;

  typedef enum logic [STS_W-1:0] {
    STS_PUSH_OK   = 2'd0,
    STS_READ_OK   = 2'd1,
    STS_FULL      = 2'd2,
    STS_OUT_RANGE = 2'd3
  } mideq_sts_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take request, issue memory reads
    logic commit;   // do writes, update pointers, load result
  } mideq_cmd_t;

endpackage

// ===== hw/rtl/mideq_ctrl.sv =====
module mideq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mideq_pkg::mideq_cmd_t  cmd
);
  import mideq_pkg::*;
  `include "middle_insert_deque_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall    = (state_r != ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = (state_r == ST_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MID_ASSERT_NEXT(a_capture_exec, cmd.capture, state_r == ST_EXEC, "capture did not enter exec")
  `MID_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_r, "commit left no result")
  `MID_ASSERT_ALWAYS(a_cmd_excl, !(cmd.capture && cmd.commit), "capture and commit together")
  `MID_ASSERT_ALWAYS(a_no_overwrite, !(cmd.commit && out_valid_r && out_stall),
                     "result overwritten while stalled")

endmodule

// ===== hw/rtl/mideq_dp.sv =====
module mideq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mideq_pkg::mideq_cmd_t               cmd,
  input  logic [mideq_pkg::REQ_W-1:0]         in_req_type,
  input  logic [mideq_pkg::DATA_WIDTH-1:0]    in_push_value,
  input  logic [mideq_pkg::IDX_W-1:0]         in_read_index,
  output logic [mideq_pkg::DATA_WIDTH-1:0]    out_read_data,
  output logic [mideq_pkg::STS_W-1:0]         out_status,
  output logic [mideq_pkg::TW-1:0]            out_total_count
);
  import mideq_pkg::*;
  `include "middle_insert_deque_assert.svh"

  // ring state
  logic [AW-1:0] lhead_r, lhead_nxt, rhead_r, rhead_nxt;
  logic [CW-1:0] lcount_r, lcount_nxt, rcount_r, rcount_nxt;

  // captured request
  mideq_req_t      req_r;
  mideq_sts_t      sts_r, sts_nxt;
  logic            sel_left_r;
  logic [DATA_WIDTH-1:0] val_r;

  // memories
  logic [DATA_WIDTH-1:0] lmem [HALF_DEPTH];
  logic [DATA_WIDTH-1:0] rmem [HALF_DEPTH];
  logic [DATA_WIDTH-1:0] lrd_r, rrd_r;
  logic [AW-1:0]         lra, rra, lwa, rwa;
  logic [DATA_WIDTH-1:0] lwd, rwd;
  logic                  lwe, rwe;

  logic [TW-1:0]   total, idx_ext, rel_idx, total_nxt;
  logic            idx_left, balanced;
  logic [CW-1:0]   lcount_m1;

  // output registers
  logic [DATA_WIDTH-1:0] rdata_r;
  mideq_sts_t            osts_r;
  logic [TW-1:0]         ototal_r;

  assign total     = TW'(lcount_r) + TW'(rcount_r);
  assign idx_ext   = TW'(in_read_index);
  assign rel_idx   = idx_ext - TW'(lcount_r);
  assign idx_left  = idx_ext < TW'(lcount_r);
  assign lcount_m1 = lcount_r - CW'(1);
  assign balanced  = (lcount_r == rcount_r);

  // Read addresses for the capture cycle. Reads pick their half by index;
  // push back pulls the right head, push front pulls the left tail.
  always_comb begin
    if (mideq_req_t'(in_req_type) == REQ_READ) begin
      lra = lhead_r + in_read_index[AW-1:0];
      rra = rhead_r + rel_idx[AW-1:0];
    end else begin
      lra = lhead_r + lcount_m1[AW-1:0];
      rra = rhead_r;
    end
  end

  always_comb begin
    if (mideq_req_t'(in_req_type) == REQ_READ) begin
      sts_nxt = (idx_ext >= total) ? STS_OUT_RANGE : STS_READ_OK;
    end else begin
      sts_nxt = (total >= TW'(2 * HALF_DEPTH)) ? STS_FULL : STS_PUSH_OK;
    end
  end

  // Write plan for the commit cycle; counts are unchanged since capture.
  always_comb begin
    lhead_nxt  = lhead_r;
    rhead_nxt  = rhead_r;
    lcount_nxt = lcount_r;
    rcount_nxt = rcount_r;
    lwe = 1'b0;
    rwe = 1'b0;
    lwa = lhead_r + lcount_r[AW-1:0];
    rwa = rhead_r + rcount_r[AW-1:0];
    lwd = val_r;
    rwd = val_r;
    if (sts_r == STS_PUSH_OK) begin
      case (req_r)
        REQ_PUSH_BACK: begin
          if (!balanced) begin
            rwe        = 1'b1;
            rcount_nxt = rcount_r + CW'(1);
          end else begin
            lwe        = 1'b1;
            lcount_nxt = lcount_r + CW'(1);
            if (rcount_r != '0) begin
              // right head crosses to left tail, value to right tail
              lwd       = rrd_r;
              rwe       = 1'b1;
              rhead_nxt = rhead_r + AW'(1);
            end
          end
        end
        REQ_PUSH_FRONT: begin
          lwe       = 1'b1;
          lwa       = lhead_r - AW'(1);
          lhead_nxt = lhead_r - AW'(1);
          if (!balanced) begin
            // left tail crosses to right head
            rwe        = 1'b1;
            rwa        = rhead_r - AW'(1);
            rwd        = lrd_r;
            rhead_nxt  = rhead_r - AW'(1);
            rcount_nxt = rcount_r + CW'(1);
          end else begin
            lcount_nxt = lcount_r + CW'(1);
          end
        end
        REQ_PUSH_MIDDLE: begin
          if (balanced) begin
            lwe        = 1'b1;
            lcount_nxt = lcount_r + CW'(1);
          end else begin
            rwe        = 1'b1;
            rwa        = rhead_r - AW'(1);
            rhead_nxt  = rhead_r - AW'(1);
            rcount_nxt = rcount_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign total_nxt = TW'(lcount_nxt) + TW'(rcount_nxt);

  always_ff @(posedge clk) begin
    if (cmd.commit && lwe) lmem[lwa] <= lwd;
    if (cmd.capture) lrd_r <= lmem[lra];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && rwe) rmem[rwa] <= rwd;
    if (cmd.capture) rrd_r <= rmem[rra];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= mideq_req_t'(in_req_type);
      val_r      <= in_push_value;
      sel_left_r <= idx_left;
    end
    if (cmd.commit) begin
      osts_r   <= sts_r;
      ototal_r <= total_nxt;
      if (sts_r == STS_READ_OK) begin
        rdata_r <= sel_left_r ? lrd_r : rrd_r;
      end else begin
        rdata_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhead_r  <= '0;
      rhead_r  <= '0;
      lcount_r <= '0;
      rcount_r <= '0;
      sts_r    <= STS_PUSH_OK;
    end else begin
      if (cmd.capture) sts_r <= sts_nxt;
      if (cmd.commit) begin
        lhead_r  <= lhead_nxt;
        rhead_r  <= rhead_nxt;
        lcount_r <= lcount_nxt;
        rcount_r <= rcount_nxt;
      end
    end
  end

  assign out_read_data   = rdata_r;
  assign out_status      = osts_r;
  assign out_total_count = ototal_r;

  `MID_ASSERT_ALWAYS(a_balance, (lcount_r == rcount_r) || (lcount_r == rcount_r + CW'(1)),
                     "halves out of balance")
  `MID_ASSERT_ALWAYS(a_total_cap, total <= TW'(2 * HALF_DEPTH), "total exceeds capacity")
  `MID_ASSERT_NEXT(a_idle_hold, !cmd.commit, $stable(lcount_r) && $stable(rcount_r),
                   "counts moved without commit")

endmodule

// ===== hw/rtl/middle_insert_deque.sv =====
// Middle-insert deque: a sequence of up to 1024 32-bit entries held as two
// ring-buffer halves of 512 entries each. The left half holds the front of
// the sequence and always has as many entries as the right half or one more,
// so a push at the middle lands at the tail of the left half or the head of
// the right half. Request codes on in_req_type: 0 push back, 1 push front,
// 2 push middle, 3 read in_read_index. Every request gives exactly one result
// beat: out_status 0 push done, 1 read done, 2 store full (nothing changed),
// 3 index out of range (nothing changed); out_read_data is the entry on a
// good read and zero otherwise; out_total_count is the entry count after the
// request. Timing: a request takes a capture step that reads the two entry
// memories (a read result, or the entry that crosses between halves) and a
// commit step that writes them and loads the result register. The result
// waits in that register while the next request is taken; a new request is
// held off only while one is in flight, and if the previous result is still
// stalled at commit time the request waits there. Entry memories come up
// with no reset and need none: only written entries are ever used.
module middle_insert_deque (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mideq_pkg::REQ_W-1:0]         in_req_type,
  input  logic [mideq_pkg::DATA_WIDTH-1:0]    in_push_value,
  input  logic [mideq_pkg::IDX_W-1:0]         in_read_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mideq_pkg::DATA_WIDTH-1:0]    out_read_data,
  output logic [mideq_pkg::STS_W-1:0]         out_status,
  output logic [mideq_pkg::TW-1:0]            out_total_count
);
  import mideq_pkg::*;

  mideq_cmd_t cmd;

  // sequencing: accept, then commit once the result register is free
  mideq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // halves, ring pointers, entry memories and result register
  mideq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .in_read_index   (in_read_index),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .out_total_count (out_total_count)
  );

endmodule
